// ----- design/csp_pkg.sv -----
// Package for the cylinder surface projection block.
// Holds the coordinate width, the payload and queue-entry types and register indexes.
// No dependencies.
`default_nettype none

package csp_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int CFG_WIDTH   = COORD_WIDTH - 1;

   typedef enum logic [0:0] {
      CSR_HALF_LENGTH = 1'b0,
      CSR_CYL_RADIUS  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] proj_x;
      logic signed [COORD_WIDTH-1:0] proj_y;
      logic signed [COORD_WIDTH-1:0] proj_z;
      logic                          is_inside;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] px;
      logic [COORD_WIDTH-1:0]        ay;
      logic [COORD_WIDTH-1:0]        az;
      logic                          ys;
      logic                          zs;
      logic                          to_wall;
      logic                          in_cyl;
      logic [2*COORD_WIDTH-1:0]      s;
   } work_type;

endpackage

`default_nettype wire

// ----- design/cylinder_surface_projection.sv -----
// Top level of the capped-cylinder surface projection block.
// Depends on csp_pkg, csp_front, csp_fifo and csp_back.
`default_nettype none

// Takes one point per clock while req_stall is low and returns its nearest point on a capped
// cylinder along x, plus an inside flag. The back section holds a bit-per-stage square root
// and bit-per-stage dividers for the radial scaling. A four-entry queue lets the front keep
// accepting while results wait. Write half_length and cyl_radius only while idle.
module cylinder_surface_projection
   import csp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [0:0]           csr_index,
   input  wire logic [CFG_WIDTH-1:0] csr_wdata
);

   logic [CFG_WIDTH-1:0]   half_length_ff, cyl_radius_ff;
   logic [2*CFG_WIDTH-1:0] rad_sq_ff;

   logic     push_valid, fifo_full, fifo_valid, back_pop;
   work_type push_data, fifo_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_length_ff <= CFG_WIDTH'(65536);
         cyl_radius_ff  <= CFG_WIDTH'(65536);
      end else if (csr_we) begin
         case (csr_index)
            CSR_HALF_LENGTH: begin
               half_length_ff <= csr_wdata;
            end
            CSR_CYL_RADIUS: begin
               cyl_radius_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rad_sq_ff <= cyl_radius_ff * cyl_radius_ff;
   end

   csp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .half_length (half_length_ff),
      .cyl_radius  (cyl_radius_ff),
      .rad_sq      (rad_sq_ff),
      .push_valid  (push_valid),
      .push_ready  (!fifo_full),
      .push_data   (push_data)
   );

   csp_fifo #(
      .WIDTH ($bits(work_type)),
      .DEPTH (4)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (back_pop),
      .out_valid (fifo_valid),
      .out_data  (fifo_data)
   );

   csp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (fifo_valid),
      .work_data  (fifo_data),
      .work_pop   (back_pop),
      .cyl_radius (cyl_radius_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // Reset empties both the queue and the result register.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && !fifo_valid)
      else $error("pipeline not empty after reset");

   // A queued transaction that the back section does not take stays queued.
   a_queue_hold : assert property (@(posedge clock) disable iff (reset)
      fifo_valid && !back_pop |=> fifo_valid)
      else $error("queued transaction lost");

   // The back section only takes work when the result side can move.
   a_pop_gated : assert property (@(posedge clock) disable iff (reset)
      back_pop |-> fifo_valid && (!rsp_valid || !rsp_stall))
      else $error("queue popped while result stalled");

endmodule

`default_nettype wire

// ----- design/csp_fifo.sv -----
// Small first-in first-out queue between the front and back sections.
// Generic width and depth; no package dependencies.
`default_nettype none

module csp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  out_valid,
   output logic [WIDTH-1:0]      out_data
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNTW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- design/csp_front.sv -----
// Front section: takes points, squares and compares them, and decides cap or wall.
// Depends on csp_pkg for the payload and queue-entry types.
`default_nettype none

module csp_front
   import csp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   input  wire logic [CFG_WIDTH-1:0]   half_length,
   input  wire logic [CFG_WIDTH-1:0]   cyl_radius,
   input  wire logic [2*CFG_WIDTH-1:0] rad_sq,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output work_type                    push_data
);

   localparam int W = COORD_WIDTH;

   logic rdy1, rdy2, rdy3;
   logic v1_ff, v2_ff, v3_ff;
   req_type p1_ff;

   logic [W-1:0]        ax_in, ay_in, az_in;
   logic signed [W-1:0] len_s, px_clamp_in, px_cap_in;
   logic signed [W+1:0] t_in;
   logic                in_x_in, t_ok_in;

   logic signed [W-1:0] px_clamp2_ff, px_cap2_ff;
   logic [W-1:0]        ay2_ff, az2_ff;
   logic                ys2_ff, zs2_ff, in_x2_ff, t_ok2_ff;
   logic [2*W-1:0]      ysq2_ff, zsq2_ff;
   logic [W-2:0]        tm2_ff;

   logic signed [W-1:0] px_clamp3_ff, px_cap3_ff;
   logic [W-1:0]        ay3_ff, az3_ff;
   logic                ys3_ff, zs3_ff, in_x3_ff, t_ok3_ff;
   logic [2*W-1:0]      s3_ff;
   logic [2*W-3:0]      tsq3_ff;

   logic within_r, cap_near;

   assign rdy3      = !v3_ff || push_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_comb begin
      len_s   = $signed({1'b0, half_length});
      ax_in   = p1_ff.point_x[W-1] ? (~p1_ff.point_x + 1'b1) : p1_ff.point_x;
      ay_in   = p1_ff.point_y[W-1] ? (~p1_ff.point_y + 1'b1) : p1_ff.point_y;
      az_in   = p1_ff.point_z[W-1] ? (~p1_ff.point_z + 1'b1) : p1_ff.point_z;
      in_x_in = (ax_in <= {1'b0, half_length});
      t_in    = $signed({3'b000, cyl_radius}) + $signed({2'b00, ax_in})
              - $signed({3'b000, half_length});
      t_ok_in = in_x_in && !t_in[W+1] && (t_in != '0);
      if (p1_ff.point_x > len_s) begin
         px_clamp_in = len_s;
      end else if (p1_ff.point_x < -len_s) begin
         px_clamp_in = -len_s;
      end else begin
         px_clamp_in = p1_ff.point_x;
      end
      px_cap_in = (p1_ff.point_x > 0) ? len_s : -len_s;
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         p1_ff <= req_data;
      end
      if (rdy2 && v1_ff) begin
         px_clamp2_ff <= px_clamp_in;
         px_cap2_ff   <= px_cap_in;
         ay2_ff       <= ay_in;
         az2_ff       <= az_in;
         ys2_ff       <= p1_ff.point_y[W-1];
         zs2_ff       <= p1_ff.point_z[W-1];
         in_x2_ff     <= in_x_in;
         t_ok2_ff     <= t_ok_in;
         ysq2_ff      <= ay_in * ay_in;
         zsq2_ff      <= az_in * az_in;
         tm2_ff       <= t_in[W-2:0];
      end
      if (rdy3 && v2_ff) begin
         px_clamp3_ff <= px_clamp2_ff;
         px_cap3_ff   <= px_cap2_ff;
         ay3_ff       <= ay2_ff;
         az3_ff       <= az2_ff;
         ys3_ff       <= ys2_ff;
         zs3_ff       <= zs2_ff;
         in_x3_ff     <= in_x2_ff;
         t_ok3_ff     <= t_ok2_ff;
         s3_ff        <= ysq2_ff + zsq2_ff;
         tsq3_ff      <= tm2_ff * tm2_ff;
      end
   end

   always_comb begin
      within_r          = (s3_ff <= {2'b00, rad_sq});
      cap_near          = t_ok3_ff && (s3_ff < {2'b00, tsq3_ff});
      push_valid        = v3_ff;
      push_data.ay      = ay3_ff;
      push_data.az      = az3_ff;
      push_data.ys      = ys3_ff;
      push_data.zs      = zs3_ff;
      push_data.s       = s3_ff;
      push_data.in_cyl  = in_x3_ff && within_r;
      push_data.to_wall = !within_r || (in_x3_ff && !cap_near);
      push_data.px      = (within_r && in_x3_ff && cap_near) ? px_cap3_ff : px_clamp3_ff;
   end

endmodule

`default_nettype wire

// ----- design/csp_back.sv -----
// Back section: square root, radial scaling by division and result register.
// Depends on csp_pkg for the queue-entry and result types.
`default_nettype none

module csp_back
   import csp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 work_valid,
   input  wire work_type             work_data,
   output logic                      work_pop,
   input  wire logic [CFG_WIDTH-1:0] cyl_radius,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data
);

   localparam int W = COORD_WIDTH;

   logic adv;

   logic           sq_v_ff    [0:W];
   work_type       sq_w_ff    [0:W];
   logic [W+1:0]   sq_rem_ff  [0:W];
   logic [W-1:0]   sq_root_ff [0:W];

   logic           md_v_ff;
   work_type       md_w_ff;
   logic [W-1:0]   md_n_ff;
   logic [2*W-2:0] md_ny_ff, md_nz_ff;

   logic           dv_v_ff  [0:W-1];
   work_type       dv_w_ff  [0:W-1];
   logic [W-1:0]   dv_n_ff  [0:W-1];
   logic [W-1:0]   dv_ry_ff [0:W-1];
   logic [W-1:0]   dv_rz_ff [0:W-1];
   logic [W-2:0]   dv_ly_ff [0:W-1];
   logic [W-2:0]   dv_lz_ff [0:W-1];
   logic [W-2:0]   dv_qy_ff [0:W-1];
   logic [W-2:0]   dv_qz_ff [0:W-1];

   logic           rsp_v_ff;
   rsp_type        rsp_ff, rsp_in;

   assign adv       = !rsp_v_ff || !rsp_stall;
   assign work_pop  = adv && work_valid;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= work_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_w_ff[0]    <= work_data;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar g = 0; g < W; g++) begin : g_sqrt
      logic [W+1:0] cur, trial;
      logic         take;

      always_comb begin
         cur   = {sq_rem_ff[g][W-1:0], sq_w_ff[g].s[2*W-1-2*g -: 2]};
         trial = {sq_root_ff[g], 2'b01};
         take  = (cur >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[g+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[g+1] <= sq_v_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_w_ff[g+1]    <= sq_w_ff[g];
            sq_rem_ff[g+1]  <= take ? (cur - trial) : cur;
            sq_root_ff[g+1] <= {sq_root_ff[g][W-2:0], take};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         md_v_ff <= 1'b0;
      end else if (adv) begin
         md_v_ff <= sq_v_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         md_w_ff  <= sq_w_ff[W];
         md_n_ff  <= sq_root_ff[W] + W'(sq_rem_ff[W] != '0);
         md_ny_ff <= sq_w_ff[W].ay * cyl_radius;
         md_nz_ff <= sq_w_ff[W].az * cyl_radius;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= md_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_w_ff[0]  <= md_w_ff;
         dv_n_ff[0]  <= md_n_ff;
         dv_ry_ff[0] <= md_ny_ff[2*W-2:W-1];
         dv_rz_ff[0] <= md_nz_ff[2*W-2:W-1];
         dv_ly_ff[0] <= md_ny_ff[W-2:0];
         dv_lz_ff[0] <= md_nz_ff[W-2:0];
         dv_qy_ff[0] <= '0;
         dv_qz_ff[0] <= '0;
      end
   end

   for (genvar d = 0; d < W - 1; d++) begin : g_div
      logic [W:0] cy, cz, nd;
      logic       gy, gz;

      always_comb begin
         nd = {1'b0, dv_n_ff[d]};
         cy = {dv_ry_ff[d], dv_ly_ff[d][W-2-d]};
         cz = {dv_rz_ff[d], dv_lz_ff[d][W-2-d]};
         gy = (cy >= nd);
         gz = (cz >= nd);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[d+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[d+1] <= dv_v_ff[d];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_w_ff[d+1]  <= dv_w_ff[d];
            dv_n_ff[d+1]  <= dv_n_ff[d];
            dv_ly_ff[d+1] <= dv_ly_ff[d];
            dv_lz_ff[d+1] <= dv_lz_ff[d];
            dv_ry_ff[d+1] <= gy ? W'(cy - nd) : cy[W-1:0];
            dv_rz_ff[d+1] <= gz ? W'(cz - nd) : cz[W-1:0];
            dv_qy_ff[d+1] <= {dv_qy_ff[d][W-3:0], gy};
            dv_qz_ff[d+1] <= {dv_qz_ff[d][W-3:0], gz};
         end
      end
   end

   always_comb begin
      logic [W-2:0] qy, qz;
      logic [W-1:0] my, mz;
      logic [W:0]   nd;
      work_type     wk;

      wk = dv_w_ff[W-1];
      nd = {1'b0, dv_n_ff[W-1]};
      qy = dv_qy_ff[W-1] + (W-1)'({dv_ry_ff[W-1], 1'b0} >= nd);
      qz = dv_qz_ff[W-1] + (W-1)'({dv_rz_ff[W-1], 1'b0} >= nd);
      my = {1'b0, qy};
      mz = {1'b0, qz};
      rsp_in.proj_x    = wk.px;
      rsp_in.is_inside = wk.in_cyl;
      if (!wk.to_wall) begin
         rsp_in.proj_y = wk.ys ? (~wk.ay + 1'b1) : wk.ay;
         rsp_in.proj_z = wk.zs ? (~wk.az + 1'b1) : wk.az;
      end else if (dv_n_ff[W-1] == '0) begin
         rsp_in.proj_y = {1'b0, cyl_radius};
         rsp_in.proj_z = '0;
      end else begin
         rsp_in.proj_y = wk.ys ? (~my + 1'b1) : my;
         rsp_in.proj_z = wk.zs ? (~mz + 1'b1) : mz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= dv_v_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for cylinder_surface_projection: random and directed points, scored against
// a behavioral model of the capped-cylinder projection with radial rounding.
// Depends on csp_pkg and the design sources.
`default_nettype none

module tb
   import csp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 2*COORD_WIDTH + 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = 1'b0;
   logic [CFG_WIDTH-1:0] csr_wdata = '0;

   logic [CFG_WIDTH-1:0] half_len_reg = CFG_WIDTH'(65536);
   logic [CFG_WIDTH-1:0] radius_reg = CFG_WIDTH'(65536);

   req_type pending_points[$];
   rsp_type expected_projections[$];
   int errors = 0;
   int received = 0;
   int sent = 0;
   bit hold_off = 1'b0;
   int burst_left = 0;
   int gap_left = 0;

   cylinder_surface_projection DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] ceil_root(logic [63:0] s);
      logic [63:0] r;
      logic [63:0] c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= s) r = c;
      end
      if (r * r < s) r = r + 1;
      return r;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] scale_axis(logic signed [63:0] v,
                                                                 logic [63:0] n);
      logic [63:0] mag;
      logic [127:0] prod;
      logic [127:0] q;
      logic [127:0] rem;
      mag = v < 0 ? -v : v;
      prod = 128'(mag) * 128'(radius_reg);
      q = prod / n;
      rem = prod % n;
      if (rem >= 128'(n) - rem) q = q + 1;
      return v < 0 ? COORD_WIDTH'(-q) : COORD_WIDTH'(q);
   endfunction

   function automatic rsp_type project_point(req_type p);
      rsp_type r;
      logic signed [63:0] x, y, z, ax, len, rad, px, t;
      logic [63:0] s, r2, n;
      logic in_x, within_r, to_wall;
      x = p.point_x; y = p.point_y; z = p.point_z;
      len = half_len_reg; rad = radius_reg;
      ax = x < 0 ? -x : x;
      s = y * y + z * z;
      r2 = 64'(radius_reg) * 64'(radius_reg);
      in_x = ax <= len;
      within_r = s <= r2;
      to_wall = 1'b0;
      px = x;
      if (x > len) px = len;
      else if (x < -len) px = -len;
      if (!within_r) to_wall = 1'b1;
      else if (in_x) begin
         t = rad + ax - len;
         if (t > 0 && s < 64'(t) * 64'(t)) px = x > 0 ? len : -len;
         else to_wall = 1'b1;
      end
      r.proj_x = COORD_WIDTH'(px);
      r.proj_y = p.point_y;
      r.proj_z = p.point_z;
      if (to_wall) begin
         n = ceil_root(s);
         if (n == 0) begin
            r.proj_y = COORD_WIDTH'(rad);
            r.proj_z = '0;
         end else begin
            r.proj_y = scale_axis(y, n);
            r.proj_z = scale_axis(z, n);
         end
      end
      r.is_inside = in_x && within_r;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_projections.push_back(project_point(req_data));
            sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_points.size() > 0 && gap_left == 0) begin
               req_data <= pending_points.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
                  if (burst_left == 0 && gap_left == 0) gap_left = $urandom_range(0, 5);
                  else if (burst_left > 0) gap_left = 0;
               end
            end else begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            received++;
            if (expected_projections.size() == 0) begin
               errors++;
               if (errors <= 10) $display("ERROR: unexpected transaction %p", rsp_data);
            end else begin
               want = expected_projections.pop_front();
               if (rsp_data !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("ERROR: transaction %0d expected %p got %p", received, want,
                              rsp_data);
               end
            end
         end
         if (hold_off) rsp_stall <= 1'b1;
         else rsp_stall <= (($urandom_range(0, 15) < 5) && (received % 300 > 60));
      end
   end

   task automatic drain();
      while (pending_points.size() > 0 || req_valid || expected_projections.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CFG_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HALF_LENGTH) half_len_reg = value;
      else radius_reg = value;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int scale);
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $signed($urandom_range(0, scale)) - $signed($urandom_range(0, scale));
         2: return $signed($urandom_range(0, 2 * scale)) - scale;
         3: return $urandom_range(0, 3) - 1;
         default: return $signed($urandom_range(0, 8 * scale)) - 4 * scale;
      endcase
   endfunction

   task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
      req_type p;
      p.point_x = x; p.point_y = y; p.point_z = z;
      pending_points.push_back(p);
   endtask

   initial begin
      logic [CFG_WIDTH-1:0] lens[6];
      logic [CFG_WIDTH-1:0] rads[6];
      int scale;
      lens = '{CFG_WIDTH'(65536), 0, {CFG_WIDTH{1'b1}}, CFG_WIDTH'(200000),
               CFG_WIDTH'($urandom), CFG_WIDTH'(3)};
      rads = '{CFG_WIDTH'(65536), CFG_WIDTH'(131072), 0, {CFG_WIDTH{1'b1}},
               CFG_WIDTH'($urandom), CFG_WIDTH'(100000)};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      add_point(0, 0, 0);
      add_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      add_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
      add_point(32'sh80000000, 0, 0);
      add_point(200000, 1000, -1000);
      add_point(-200000, 0, 0);
      add_point(30000, 0, 0);
      add_point(60000, 10000, 0);
      add_point(0, 60000, 0);
      add_point(0, 0, -65536);
      add_point(65536, 65536, 0);
      add_point(-65536, 46341, 46341);
      add_point(40000, -30000, 20000);
      add_point(-1, 65535, 0);
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         write_reg(CSR_HALF_LENGTH, lens[phase]);
         write_reg(CSR_CYL_RADIUS, rads[phase]);
         scale = (phase == 2 || phase == 3 || phase == 4) ? 32'h7fffffff : 300000;
         for (int i = 0; i < 300; i++)
            add_point(rand_coord(scale), rand_coord(scale), rand_coord(scale));
         add_point(rand_coord(scale), 0, 0);
         if (phase == 1) begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         drain();
      end
      $display("Covered %0d transactions over six register settings including extremes.",
               received);
      if (errors == 0 && expected_projections.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Mismatches: %0d", errors);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout");
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
design/csp_pkg.sv
design/csp_fifo.sv
design/csp_front.sv
design/csp_back.sv
design/cylinder_surface_projection.sv
sim/tb.sv
